FILE: rtl/core/vnorm_pkg.sv
// Package for the vector normalizer: widths, stage counts and payload types.
`default_nettype none
package vnorm_pkg;

  // Component and result formats
  localparam int IN_W   = 16;          // signed Q8.8 input component
  localparam int FRAC   = 14;          // fraction bits of the unit result
  localparam int OUT_W  = FRAC + 2;    // signed Q1.FRAC result
  localparam int LANES  = 3;

  // Internal widths
  localparam int SQ_W   = 2 * IN_W;                // one squared magnitude
  localparam int SUM_W  = 2 * IN_W;                // sum of three squares fits
  localparam int Q_W    = FRAC + 1;                // quotient magnitude <= 2^FRAC
  localparam int A_W    = Q_W + SUM_W;             // q * S
  localparam int D_W    = 2 * Q_W + SUM_W;         // cand^2 * S and the remainder

  // Pipeline depth
  localparam int FRONT_STG = 3;                    // magnitude, square, sum
  localparam int LANE_STG  = Q_W + 1;              // one stage per result bit, output
  localparam int NSTG      = FRONT_STG + LANE_STG;

  typedef logic [IN_W-1:0]  mag_t;
  typedef logic [SQ_W-1:0]  sq_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [D_W-1:0]   rem_t;
  typedef logic [A_W-1:0]   acc_t;
  typedef logic [Q_W-1:0]   quo_t;
  typedef logic [OUT_W-1:0] unit_t;

endpackage
`default_nettype wire

FILE: rtl/core/vector_normalize.sv
// Top level: three-lane pipelined 3D vector normalizer, Q8.8 in, Q1.14 out.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | valid_i, stall_o, vec_x_i/vec_y_i/vec_z_i | in
//   output   | valid_o, stall_i, unit_x_o/y/z, zero_len  | out
//
// One vector per cycle while stall_i stays low; 3 front stages, 15 quotient-bit stages
// per lane (one stage per result bit) and 1 output stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when empty or when the stage after it moves, so bubbles collapse
// and input keeps flowing into empty stages while a finished result waits on stall_i.
`default_nettype none
module vector_normalize (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [vnorm_pkg::IN_W-1:0] vec_x_i,
  input  logic signed [vnorm_pkg::IN_W-1:0] vec_y_i,
  input  logic signed [vnorm_pkg::IN_W-1:0] vec_z_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [vnorm_pkg::OUT_W-1:0] unit_x_o,
  output logic signed [vnorm_pkg::OUT_W-1:0] unit_y_o,
  output logic signed [vnorm_pkg::OUT_W-1:0] unit_z_o,
  output logic                              zero_length_o
);
  import vnorm_pkg::*;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   free;
  logic signed [IN_W-1:0] comp [LANES];
  sum_t  sum;
  rem_t  tgt  [LANES];
  logic  neg  [LANES];
  logic  zero;
  unit_t unit [LANES];
  logic  zr_q [LANE_STG];

  // Stage load enables, computed back from the output
  always_comb begin
    free[NSTG] = !stall_i;
    for (int s = NSTG - 1; s >= 0; s--) free[s] = !vld_q[s] || free[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (free[s]) vld_q[s] <= (s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign stall_o = !free[0];

  assign comp[0] = vec_x_i;
  assign comp[1] = vec_y_i;
  assign comp[2] = vec_z_i;

  vnorm_front u_front (
    .clk_i  (clk_i),
    .en_i   (free[FRONT_STG-1:0]),
    .comp_i (comp),
    .sum_o  (sum),
    .tgt_o  (tgt),
    .neg_o  (neg),
    .zero_o (zero)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vnorm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (free[NSTG-1:FRONT_STG]),
      .sum_i  (sum),
      .tgt_i  (tgt[l]),
      .neg_i  (neg[l]),
      .unit_o (unit[l])
    );
  end

  // Zero-length flag rides alongside the lanes
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANE_STG; k++) begin
      if (free[FRONT_STG + k]) zr_q[k] <= (k == 0) ? zero : zr_q[(k == 0) ? 0 : k - 1];
    end
  end

  assign valid_o       = vld_q[NSTG-1];
  assign unit_x_o      = unit[0];
  assign unit_y_o      = unit[1];
  assign unit_z_o      = unit[2];
  assign zero_length_o = zr_q[LANE_STG-1];

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_length_o |-> unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0)
    else $error("zero-length result with nonzero component");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> unit_x_o <= $signed(OUT_W'(1 << FRAC)) && unit_x_o >= -$signed(OUT_W'(1 << FRAC))
             && unit_y_o <= $signed(OUT_W'(1 << FRAC)) && unit_y_o >= -$signed(OUT_W'(1 << FRAC))
             && unit_z_o <= $signed(OUT_W'(1 << FRAC)) && unit_z_o >= -$signed(OUT_W'(1 << FRAC)))
    else $error("unit component out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> stall_i && vld_q == '1)
    else $error("input stalled while pipeline has room");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/vnorm_front.sv
// Front stages: component magnitudes, squares, squared length and per-lane targets.
`default_nettype none
module vnorm_front (
  input  logic                                  clk_i,
  input  logic [vnorm_pkg::FRONT_STG-1:0]       en_i,
  input  logic signed [vnorm_pkg::IN_W-1:0]     comp_i [vnorm_pkg::LANES],
  output vnorm_pkg::sum_t                       sum_o,
  output vnorm_pkg::rem_t                       tgt_o  [vnorm_pkg::LANES],
  output logic                                  neg_o  [vnorm_pkg::LANES],
  output logic                                  zero_o
);
  import vnorm_pkg::*;

  mag_t mag_q  [LANES];
  logic neg0_q [LANES];
  sq_t  sq_q   [LANES];
  logic neg1_q [LANES];
  sum_t sum_q;
  rem_t tgt_q  [LANES];
  logic neg2_q [LANES];
  logic zero_q;
  sum_t sum_d;

  // Stage 0: sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int l = 0; l < LANES; l++) begin
        neg0_q[l] <= comp_i[l][IN_W-1];
        mag_q[l]  <= comp_i[l][IN_W-1] ? (~comp_i[l] + mag_t'(1)) : comp_i[l];
      end
    end
  end

  // Stage 1: one square per lane
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int l = 0; l < LANES; l++) begin
        sq_q[l]   <= sq_t'(mag_q[l]) * sq_t'(mag_q[l]);
        neg1_q[l] <= neg0_q[l];
      end
    end
  end

  // Stage 2: squared length and scaled targets
  always_comb begin
    sum_d = '0;
    for (int l = 0; l < LANES; l++) sum_d = sum_d + sum_t'(sq_q[l]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum_q  <= sum_d;
      zero_q <= (sum_d == '0);
      for (int l = 0; l < LANES; l++) begin
        tgt_q[l]  <= rem_t'(sq_q[l]) << (2 * FRAC);
        neg2_q[l] <= neg1_q[l];
      end
    end
  end

  assign sum_o  = sum_q;
  assign tgt_o  = tgt_q;
  assign neg_o  = neg2_q;
  assign zero_o = zero_q;

endmodule
`default_nettype wire

FILE: rtl/core/vnorm_lane.sv
// One lane: bit-serial pipelined quotient c*2^FRAC/sqrt(S), one result bit per stage.
`default_nettype none
module vnorm_lane (
  input  logic                              clk_i,
  input  logic [vnorm_pkg::LANE_STG-1:0]    en_i,
  input  vnorm_pkg::sum_t                   sum_i,
  input  vnorm_pkg::rem_t                   tgt_i,
  input  logic                              neg_i,
  output vnorm_pkg::unit_t                  unit_o
);
  import vnorm_pkg::*;

  rem_t r_q   [Q_W];
  acc_t a_q   [Q_W];
  quo_t q_q   [Q_W];
  sum_t s_q   [Q_W];
  logic neg_q [Q_W];
  unit_t unit_q;

  // Each stage tries one bit b: accept when (2^(b+1)*q*S + 2^2b*S) fits the remainder
  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    localparam int B = FRAC - k;
    rem_t r_in;
    acc_t a_in;
    quo_t q_in;
    sum_t s_in;
    logic n_in;
    rem_t delta;
    logic take;

    if (k == 0) begin : g_first
      assign r_in = tgt_i;
      assign a_in = '0;
      assign q_in = '0;
      assign s_in = sum_i;
      assign n_in = neg_i;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign a_in = a_q[k-1];
      assign q_in = q_q[k-1];
      assign s_in = s_q[k-1];
      assign n_in = neg_q[k-1];
    end

    assign delta = (rem_t'(a_in) << (B + 1)) + (rem_t'(s_in) << (2 * B));
    assign take  = (delta <= r_in);

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        r_q[k]   <= take ? (r_in - delta) : r_in;
        a_q[k]   <= take ? (a_in + (acc_t'(s_in) << B)) : a_in;
        q_q[k]   <= take ? (q_in | (quo_t'(1) << B)) : q_in;
        s_q[k]   <= s_in;
        neg_q[k] <= n_in;
      end
    end
  end

  // Output stage: zero length forces zero, then apply sign
  always_ff @(posedge clk_i) begin
    if (en_i[Q_W]) begin
      if (s_q[Q_W-1] == '0) begin
        unit_q <= '0;
      end else if (neg_q[Q_W-1]) begin
        unit_q <= unit_t'(0) - unit_t'(q_q[Q_W-1]);
      end else begin
        unit_q <= unit_t'(q_q[Q_W-1]);
      end
    end
  end

  assign unit_o = unit_q;

endmodule
`default_nettype wire

FILE: tb/tb_vector_normalize.sv
// Testbench for the pipelined 3D vector normalizer: directed and random vectors.
`default_nettype none
module tb_vector_normalize;
  timeunit 1ns;
  timeprecision 1ps;
  import vnorm_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] ux;
    logic [OUT_W-1:0] uy;
    logic [OUT_W-1:0] uz;
    logic             zl;
  } unit_vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [IN_W-1:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic stall_o, valid_o, zero_length_o;
  logic signed [OUT_W-1:0] unit_x_o, unit_y_o, unit_z_o;

  unit_vec_t unit_q[$];
  int  n_err = 0;
  int  n_sent = 0;
  int  n_zero = 0;
  int  n_res = 0;
  bit  calm = 1'b0;

  always #5 clk_i = ~clk_i;

  vector_normalize i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .vec_x_i, .vec_y_i, .vec_z_i,
    .valid_o, .stall_i, .unit_x_o, .unit_y_o, .unit_z_o, .zero_length_o
  );

  // Exact truncated quotient: largest q with q*q*S <= c*c*2^(2*FRAC)
  function automatic logic [OUT_W-1:0] unit_comp(logic signed [IN_W-1:0] c,
                                                  logic [63:0] sumsq);
    logic [63:0]  mag;
    logic [127:0] target;
    logic [127:0] trial;
    logic [63:0]  q;
    logic [63:0]  cand;
    mag = (c < 0) ? 64'(-65'(c)) : 64'(c);
    target = 128'(mag * mag) << (2 * FRAC);
    q = '0;
    for (int b = FRAC; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      trial = 128'(cand * cand) * 128'(sumsq);
      if (trial <= target) q = cand;
    end
    if (c < 0) q = -q;
    return q[OUT_W-1:0];
  endfunction

  function automatic unit_vec_t normalize(logic signed [IN_W-1:0] x,
                                          logic signed [IN_W-1:0] y,
                                          logic signed [IN_W-1:0] z);
    unit_vec_t r;
    logic [63:0] s;
    s = 64'($signed(32'(x)) * $signed(32'(x))) + 64'($signed(32'(y)) * $signed(32'(y)))
      + 64'($signed(32'(z)) * $signed(32'(z)));
    if (s == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
    end else begin
      r = '{ux: unit_comp(x, s), uy: unit_comp(y, s), uz: unit_comp(z, s), zl: 1'b0};
    end
    return r;
  endfunction

  // Send one vector; optional idle burst first
  task automatic send_vec(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                          logic signed [IN_W-1:0] z);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    unit_q.push_back(normalize(x, y, z));
    if (x == 0 && y == 0 && z == 0) n_zero++;
    n_sent++;
    do @(posedge clk_i); while (stall_o);
  endtask

  // Output stall in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (calm) begin
        stall_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        stall_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    unit_vec_t exp_v;
    if (rst_ni && valid_o && !stall_i) begin
      n_res++;
      if (unit_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d zl=%0b", $time,
                 unit_x_o, unit_y_o, unit_z_o, zero_length_o);
        n_err++;
      end else begin
        exp_v = unit_q.pop_front();
        if (unit_x_o !== exp_v.ux) begin
          $display("%0t: unit_x expected %0d got %0d", $time, $signed(exp_v.ux), unit_x_o);
          n_err++;
        end
        if (unit_y_o !== exp_v.uy) begin
          $display("%0t: unit_y expected %0d got %0d", $time, $signed(exp_v.uy), unit_y_o);
          n_err++;
        end
        if (unit_z_o !== exp_v.uz) begin
          $display("%0t: unit_z expected %0d got %0d", $time, $signed(exp_v.uz), unit_z_o);
          n_err++;
        end
        if (zero_length_o !== exp_v.zl) begin
          $display("%0t: zero_length expected %0b got %0b", $time, exp_v.zl,
                   zero_length_o);
          n_err++;
        end
      end
    end
  end

  // Extremes, axes, zero vector, 2D vectors
  task automatic test_directed();
    send_vec(0, 0, 0);
    send_vec(16'sh7fff, 0, 0);
    send_vec(-16'sh8000, 0, 0);
    send_vec(0, 16'sh7fff, 0);
    send_vec(0, -16'sh8000, 0);
    send_vec(0, 0, 16'sh7fff);
    send_vec(0, 0, -16'sh8000);
    send_vec(1, 0, 0);
    send_vec(0, -1, 0);
    send_vec(0, 0, 1);
    send_vec(-16'sh8000, -16'sh8000, -16'sh8000);
    send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vec(16'sh7fff, -16'sh8000, 1);
    send_vec(1, 1, 1);
    send_vec(-1, -1, -1);
    send_vec(300, 400, 0);
    send_vec(-768, 1024, 0);
    send_vec(256, 512, 512);
    send_vec(0, 0, 0);
    send_vec(16'sh5555, -16'sh2aab, 16'sh00ff);
  endtask

  // Random 3D, 2D and small-magnitude vectors
  task automatic test_random(int n);
    logic signed [IN_W-1:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          x = $signed(IN_W'($urandom_range(0, 15)) - IN_W'(8));
          y = $signed(IN_W'($urandom_range(0, 15)) - IN_W'(8));
          z = $signed(IN_W'($urandom_range(0, 15)) - IN_W'(8));
        end
        1: begin
          x = $signed(IN_W'($urandom));
          y = $signed(IN_W'($urandom));
          z = '0;
        end
        default: begin
          x = $signed(IN_W'($urandom));
          y = $signed(IN_W'($urandom));
          z = $signed(IN_W'($urandom));
        end
      endcase
      send_vec(x, y, z);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1600);
    calm = 1'b1;
    test_random(200);
    valid_i <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (NSTG + 5) @(posedge clk_i);
    $display("Sent %0d vectors (%0d zero), checked %0d results, %0d mismatches.",
             n_sent, n_zero, n_res, n_err);
    if (n_err == 0) $display("[vector_normalize] OK");
    else $display("[vector_normalize] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results pending.", unit_q.size());
    $display("[vector_normalize] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/vnorm_pkg.sv
rtl/core/vnorm_front.sv
rtl/core/vnorm_lane.sv
rtl/core/vector_normalize.sv
tb/tb_vector_normalize.sv
